/* src/rgp_pkg.sv */
// Shared types, constants and helper functions of the radial gradient pixel block.
// No dependencies; rgp_shade and the top refer to it by scoped names.
package rgp_pkg;

    // Fixed-point format: unsigned Q2.FRAC_BITS
    localparam int FRAC_BITS  = 16;
    localparam int Q_W        = FRAC_BITS + 2;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

    // Texture and pixel sizes
    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = 13;
    localparam int PIX_W   = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MILLI_W    = 11;

    localparam logic [FRAC_BITS:0] F_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [Q_W-1:0]     Q_ONE = {1'b0, F_ONE};

    // Thousandths to Q format: exact reciprocal multiply for the milli range
    localparam int              MILLI_DIV   = 1000;
    localparam int              MILLI_HALF  = 500;
    localparam int              MQ_SHIFT    = 37;
    localparam longint unsigned MQ_RECIP    =
        ((64'd1 << MQ_SHIFT) + 64'(MILLI_DIV - 1)) / 64'(MILLI_DIV);
    localparam logic [MILLI_W-1:0] OUTER_RESET_MILLI = 11'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_WIDTH  = 3'd0,
        CFG_TEX_HEIGHT = 3'd1,
        CFG_CIRCLE     = 3'd2,
        CFG_MIDPOINT   = 3'd3,
        CFG_OUTER      = 3'd4,
        CFG_CENTER     = 3'd5,
        CFG_EDGE       = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pix_x;
        logic [PIX_W-1:0] pix_y;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_coverage;
        logic       alpha_only;
    } t_pix_out;

    // Per-pixel control handed to the shading stages
    typedef struct packed {
        logic [FRAC_BITS:0] mix;
        logic [FRAC_BITS:0] fade;
        logic               in_mid;
    } t_shade_in;

    // round(milli * ONE / 1000)
    function automatic logic [Q_W-1:0] milli_to_q(input logic [MILLI_W-1:0] milli);
        logic [MILLI_W+FRAC_BITS:0] num;
        logic [63:0]                prod;
        num  = {1'b0, milli, {FRAC_BITS{1'b0}}} + (MILLI_W + FRAC_BITS + 1)'(MILLI_HALF);
        prod = 64'(num) * MQ_RECIP;
        return prod[MQ_SHIFT +: Q_W];
    endfunction

endpackage

/* src/rgp_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// Gives min(floor(num / den), 2**QUO_W - 1). Uses no package items.
module rgp_divider #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 13,
    parameter int QUO_W = 18
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);
    localparam int REM_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

    logic [REM_W-1:0] r_rem [0:QUO_W-1];
    logic [DEN_W-1:0] r_den [0:QUO_W-1];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic             r_sat [0:QUO_W];

    logic [REM_W-1:0] n_rem [0:QUO_W-1];
    logic [DEN_W-1:0] n_den [0:QUO_W-1];
    logic [QUO_W-1:0] n_quo [0:QUO_W];
    logic             n_sat [0:QUO_W];
    logic [REM_W-1:0] trial [1:QUO_W];
    logic             ge    [1:QUO_W];

    // Load the dividend and flag quotients that overflow the result width
    always_comb begin
        n_rem[0] = REM_W'(i_num);
        n_den[0] = i_den;
        n_quo[0] = '0;
        n_sat[0] = REM_W'(i_num) >= (REM_W'(i_den) << QUO_W);
        for (int j = 1; j <= QUO_W; j++) begin
            trial[j] = REM_W'(r_den[j-1]) << (QUO_W - j);
            ge[j]    = r_rem[j-1] >= trial[j];
            n_quo[j] = ge[j] ? (r_quo[j-1] | (QUO_W'(1) << (QUO_W - j))) : r_quo[j-1];
            n_sat[j] = r_sat[j-1];
        end
        for (int j = 1; j < QUO_W; j++) begin
            n_rem[j] = ge[j] ? (r_rem[j-1] - trial[j]) : r_rem[j-1];
            n_den[j] = r_den[j-1];
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < QUO_W; j++) begin
                r_rem[j] <= n_rem[j];
                r_den[j] <= n_den[j];
            end
            for (int j = 0; j <= QUO_W; j++) begin
                r_quo[j] <= n_quo[j];
                r_sat[j] <= n_sat[j];
            end
        end
    end

    assign o_quo = r_sat[QUO_W] ? '1 : r_quo[QUO_W];

endmodule

/* src/rgp_isqrt.sv */
// Pipelined integer square root, one root bit per stage (floor of the root).
// Uses no package items.
module rgp_isqrt #(
    parameter int VAL_W = 38
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [VAL_W-1:0]   i_val,
    output logic [VAL_W/2-1:0] o_root
);
    localparam int STEPS = VAL_W / 2;

    logic [VAL_W-1:0] r_val  [0:STEPS-1];
    logic [VAL_W-1:0] r_root [0:STEPS];

    logic [VAL_W-1:0] n_val  [0:STEPS-1];
    logic [VAL_W-1:0] n_root [0:STEPS];
    logic [VAL_W-1:0] bitv   [1:STEPS];
    logic [VAL_W-1:0] sum    [1:STEPS];
    logic             ge     [1:STEPS];

    // Resolve one root bit per stage, highest first
    always_comb begin
        n_val[0]  = i_val;
        n_root[0] = '0;
        for (int k = 1; k <= STEPS; k++) begin
            bitv[k]   = VAL_W'(1) << (2 * (STEPS - k));
            sum[k]    = r_root[k-1] + bitv[k];
            ge[k]     = r_val[k-1] >= sum[k];
            n_root[k] = ge[k] ? ((r_root[k-1] >> 1) + bitv[k]) : (r_root[k-1] >> 1);
        end
        for (int k = 1; k < STEPS; k++) begin
            n_val[k] = ge[k] ? (r_val[k-1] - sum[k]) : r_val[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < STEPS; k++) begin
                r_val[k] <= n_val[k];
            end
            for (int k = 0; k <= STEPS; k++) begin
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[STEPS][STEPS-1:0];

endmodule

/* src/rgp_shade.sv */
// Shading stages: smoothstep fade, colour mix and coverage, three registers deep.
// Depends on rgp_pkg for the fixed-point format and the payload structs.
module rgp_shade (
    input  logic              i_clk,
    input  logic              i_en,
    input  rgp_pkg::t_shade_in i_shade,
    input  logic [31:0]       i_center,
    input  logic [31:0]       i_edge,
    output rgp_pkg::t_pix_out o_pix
);
    localparam int FB    = rgp_pkg::FRAC_BITS;
    localparam int QW    = rgp_pkg::Q_W;
    localparam int T2_W  = 2 * FB + 2;
    localparam int CH_W  = FB + 10;
    localparam int SP_W  = FB + 1 + QW;
    localparam int CV_W  = QW + 8;
    localparam logic [QW-1:0] THREE_ONE = QW'(3) << FB;

    logic [FB:0]   r_t2;
    logic [FB:0]   r_t1;
    logic          r_mid1;
    logic [7:0]    r_ch1 [0:3];
    logic [QW-1:0] r_alpha2;
    logic [7:0]    r_ch2 [0:3];
    rgp_pkg::t_pix_out r_pix;

    logic [T2_W-1:0] t2_prod;
    logic [FB:0]     inv_mix;
    logic [CH_W-1:0] ch_sum [0:3];
    logic [QW-1:0]   fac;
    logic [SP_W-1:0] s_prod;
    logic            alpha_only;
    logic [7:0]      cov_base;
    logic [CV_W-1:0] cov_prod;
    logic [7:0]      cov;

    // Stage one: square the fade and mix each channel
    always_comb begin
        t2_prod = T2_W'(i_shade.fade) * T2_W'(i_shade.fade) + T2_W'(rgp_pkg::ROUND_HALF);
        inv_mix = rgp_pkg::F_ONE - i_shade.mix;
        for (int i = 0; i < 4; i++) begin
            ch_sum[i] = CH_W'(i_center[8*i +: 8]) * CH_W'(inv_mix)
                      + CH_W'(i_edge[8*i +: 8]) * CH_W'(i_shade.mix)
                      + CH_W'(rgp_pkg::ROUND_HALF);
        end
    end

    // Stage two: smoothstep and alpha select
    always_comb begin
        fac    = THREE_ONE - {r_t1, 1'b0};
        s_prod = SP_W'(r_t2) * SP_W'(fac) + SP_W'(rgp_pkg::ROUND_HALF);
    end

    // Stage three: coverage and masking of the colour bytes
    always_comb begin
        alpha_only = i_center == i_edge;
        cov_base   = alpha_only ? i_center[31:24] : r_ch2[3];
        cov_prod   = CV_W'(cov_base) * CV_W'(r_alpha2) + CV_W'(rgp_pkg::ROUND_HALF);
        cov        = cov_prod[FB +: 8];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t2   <= t2_prod[FB +: FB + 1];
            r_t1   <= i_shade.fade;
            r_mid1 <= i_shade.in_mid;
            for (int i = 0; i < 4; i++) begin
                r_ch1[i] <= ch_sum[i][FB +: 8];
                r_ch2[i] <= r_ch1[i];
            end
            r_alpha2 <= r_mid1 ? rgp_pkg::Q_ONE : s_prod[FB +: QW];
            r_pix.out_coverage <= cov;
            r_pix.alpha_only   <= alpha_only;
            if (alpha_only || (cov == 8'd0)) begin
                r_pix.out_red   <= 8'd0;
                r_pix.out_green <= 8'd0;
                r_pix.out_blue  <= 8'd0;
            end else begin
                r_pix.out_red   <= r_ch2[0];
                r_pix.out_green <= r_ch2[1];
                r_pix.out_blue  <= r_ch2[2];
            end
        end
    end

    assign o_pix = r_pix;

endmodule

/* src/radial_gradient_pixel_top.sv */
// Radial gradient pixel generator: one pixel accepted and one RGBA or coverage result
// delivered per clock unless the result side stalls. The pixel passes the front offset
// stage, the bit-per-stage axis-offset dividers, the squaring stage, the bit-per-stage
// square root, the mix and fade dividers and the shading stages. A stall on the result
// side freezes the pipeline. Depends on rgp_pkg, rgp_divider, rgp_isqrt and rgp_shade.
module radial_gradient_pixel_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  rgp_pkg::t_pix_in                  i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output rgp_pkg::t_pix_out                 o_data,
    input  logic                              i_cfg_we,
    input  logic [rgp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rgp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int FB      = rgp_pkg::FRAC_BITS;
    localparam int QW      = rgp_pkg::Q_W;
    localparam int DW      = rgp_pkg::DIM_W;
    localparam int PW      = rgp_pkg::PIX_W;
    localparam int AX_NUM  = PW + FB;
    localparam int SQ_W    = 2 * QW;
    localparam int V_W     = 2 * QW + 2;
    localparam int MX_NUM  = QW + FB + 1;
    localparam int AX_LAT  = QW + 1;
    localparam int SR_LAT  = V_W / 2 + 1;
    localparam int MX_LAT  = FB + 2;
    localparam int SH_LAT  = 3;
    localparam int LAT     = 1 + AX_LAT + 1 + SR_LAT + MX_LAT + SH_LAT;
    localparam logic [DW-1:0] DIM_MAX = DW'(rgp_pkg::MAX_DIM);

    // Configuration registers
    logic [DW-1:0] r_tex_width;
    logic [DW-1:0] r_tex_height;
    logic          r_circle;
    logic [QW-1:0] r_mid_q;
    logic [QW-1:0] r_out_q;
    logic [31:0]   r_center;
    logic [31:0]   r_edge;

    // Pipeline state
    logic [LAT-1:0]    r_vld;
    logic [PW-1:0]     r_kx;
    logic [PW-1:0]     r_ky;
    logic [SQ_W-1:0]   r_dx2;
    logic [SQ_W-1:0]   r_dy2;
    logic [MX_LAT-1:0] r_mid_dl;
    logic [MX_LAT-1:0] r_zero_dl;

    logic          pipe_en;
    logic [DW-1:0] w_cl;
    logic [DW-1:0] h_cl;
    logic [DW-1:0] den_y;
    logic [QW-1:0] dx;
    logic [QW-1:0] dy;
    logic [QW:0]   root;
    logic [QW-1:0] distance;
    logic [QW-1:0] fade_num_hi;
    logic [QW-1:0] fade_den;
    logic [FB:0]   q_mix;
    logic [FB:0]   q_fade;
    logic          in_mid;
    logic          fade_zero;
    rgp_pkg::t_shade_in shade;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
        logic [DW-1:0] c;
        c = v;
        if (v == '0) c = DW'(1);
        else if (v > DIM_MAX) c = DIM_MAX;
        return c;
    endfunction

    // |2p+1-n| with the pixel held inside the span
    function automatic logic [PW-1:0] axis_k(input logic [PW-1:0] p, input logic [DW-1:0] n);
        logic [DW-1:0] pe;
        logic [DW:0]   t;
        logic [DW:0]   nt;
        logic [DW:0]   k;
        pe = {1'b0, p};
        if (pe > n - DW'(1)) pe = n - DW'(1);
        t  = {pe, 1'b1};
        nt = {1'b0, n};
        k  = (t >= nt) ? (t - nt) : (nt - t);
        return k[PW-1:0];
    endfunction

    // Take configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= DW'(1);
            r_tex_height <= DW'(1);
            r_circle     <= 1'b0;
            r_mid_q      <= '0;
            r_out_q      <= rgp_pkg::milli_to_q(rgp_pkg::OUTER_RESET_MILLI);
            r_center     <= '0;
            r_edge       <= '0;
        end else if (i_cfg_we) begin
            case (rgp_pkg::t_cfg_idx'(i_cfg_idx))
                rgp_pkg::CFG_TEX_WIDTH:  r_tex_width  <= i_cfg_data[DW-1:0];
                rgp_pkg::CFG_TEX_HEIGHT: r_tex_height <= i_cfg_data[DW-1:0];
                rgp_pkg::CFG_CIRCLE:     r_circle     <= i_cfg_data[0];
                rgp_pkg::CFG_MIDPOINT:
                    r_mid_q <= rgp_pkg::milli_to_q(i_cfg_data[rgp_pkg::MILLI_W-1:0]);
                rgp_pkg::CFG_OUTER:
                    r_out_q <= rgp_pkg::milli_to_q(i_cfg_data[rgp_pkg::MILLI_W-1:0]);
                rgp_pkg::CFG_CENTER:     r_center     <= i_cfg_data;
                rgp_pkg::CFG_EDGE:       r_edge       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold every stage while the result register is full and stalled
    assign pipe_en = !r_vld[LAT-1] || !i_stall;
    assign o_stall = !pipe_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign w_cl  = clamp_dim(r_tex_width);
    assign h_cl  = clamp_dim(r_tex_height);
    assign den_y = r_circle ? w_cl : h_cl;

    // Front stage: pixel offsets from the centre
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_kx <= axis_k(i_data.pix_x, w_cl);
            r_ky <= axis_k(i_data.pix_y, h_cl);
        end
    end

    rgp_divider #(.NUM_W(AX_NUM), .DEN_W(DW), .QUO_W(QW)) u_div_x (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_num (AX_NUM'({r_kx, {FB{1'b0}}}) + AX_NUM'(w_cl >> 1)),
        .i_den (w_cl),
        .o_quo (dx)
    );

    rgp_divider #(.NUM_W(AX_NUM), .DEN_W(DW), .QUO_W(QW)) u_div_y (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_num (AX_NUM'({r_ky, {FB{1'b0}}}) + AX_NUM'(den_y >> 1)),
        .i_den (den_y),
        .o_quo (dy)
    );

    // Square both offsets
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_dx2 <= SQ_W'(dx) * SQ_W'(dx);
            r_dy2 <= SQ_W'(dy) * SQ_W'(dy);
        end
    end

    rgp_isqrt #(.VAL_W(V_W)) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_val  (V_W'(r_dx2) + V_W'(r_dy2)),
        .o_root (root)
    );

    // Saturate the distance and classify it against midpoint and outer
    assign distance    = root[QW] ? '1 : root[QW-1:0];
    assign in_mid      = distance <= r_mid_q;
    assign fade_zero   = (r_out_q <= r_mid_q) || (distance >= r_out_q);
    assign fade_num_hi = r_out_q - distance;
    assign fade_den    = r_out_q - r_mid_q;

    rgp_divider #(.NUM_W(MX_NUM), .DEN_W(QW), .QUO_W(FB + 1)) u_div_mix (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_num (MX_NUM'({distance, {FB{1'b0}}}) + MX_NUM'(r_mid_q >> 1)),
        .i_den (r_mid_q),
        .o_quo (q_mix)
    );

    rgp_divider #(.NUM_W(MX_NUM), .DEN_W(QW), .QUO_W(FB + 1)) u_div_fade (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_num (MX_NUM'({fade_num_hi, {FB{1'b0}}}) + MX_NUM'(fade_den >> 1)),
        .i_den (fade_den),
        .o_quo (q_fade)
    );

    // Carry the distance flags alongside the mix and fade division
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_mid_dl  <= {r_mid_dl[MX_LAT-2:0], in_mid};
            r_zero_dl <= {r_zero_dl[MX_LAT-2:0], fade_zero};
        end
    end

    // Clamp both ratios to one; zero midpoint gives the edge colour
    always_comb begin
        shade.in_mid = r_mid_dl[MX_LAT-1];
        if (r_mid_q == '0) shade.mix = rgp_pkg::F_ONE;
        else shade.mix = (q_mix > rgp_pkg::F_ONE) ? rgp_pkg::F_ONE : q_mix;
        if (r_zero_dl[MX_LAT-1]) shade.fade = '0;
        else shade.fade = (q_fade > rgp_pkg::F_ONE) ? rgp_pkg::F_ONE : q_fade;
    end

    rgp_shade u_shade (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_shade  (shade),
        .i_center (r_center),
        .i_edge   (r_edge),
        .o_pix    (o_data)
    );

    // A held pipeline keeps its valid pattern
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pipe_en |=> $stable(r_vld))
        else $error("valid pattern moved while the pipeline was held");

    // An accepted transaction enters the first stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transaction lost at pipeline entry");

    // Coverage-only results carry no colour
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.alpha_only) |->
        (o_data.out_red == 8'd0 && o_data.out_green == 8'd0 && o_data.out_blue == 8'd0))
        else $error("colour bytes set on a coverage-only result");

    // Zero coverage forces black
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.out_coverage == 8'd0) |->
        (o_data.out_red == 8'd0 && o_data.out_green == 8'd0 && o_data.out_blue == 8'd0))
        else $error("colour bytes set where coverage is zero");

endmodule
